// ===== design/bfa_pkg.sv =====
// Package: shared types, codes and constants of the best-fit heap allocator.
`default_nettype none
package bfa_pkg;

    localparam int HEAP_WORDS_DEF = 1024;
    localparam int BYTE_W         = 13;
    localparam int TAG_W          = 16;
    localparam int HEAP_RESET     = 4096;
    localparam int HEAP_MAX       = 4096;
    localparam int HEAP_MIN       = 16;

    localparam logic [1:0] REG_HEAP_BYTES = 2'd0;

    localparam logic       OP_ALLOC = 1'b0;
    localparam logic       OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_ALLOC_FAIL = 2'd1;
    localparam logic [1:0] ST_FREE_FAIL  = 2'd2;

    typedef struct packed {
        logic        operation;
        logic [12:0] request_bytes;
        logic [11:0] payload_address;
    } req_t;

    typedef struct packed {
        logic [11:0] address;
        logic [1:0]  status;
    } rsp_t;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_FMT_HDR,
        CMD_FMT_FTR,
        CMD_LOAD,
        CMD_RD_POS,
        CMD_ACHK,
        CMD_SPL_HDR,
        CMD_SPL_FTR,
        CMD_RD_ANX,
        CMD_WR_ANX,
        CMD_AHDR,
        CMD_AFAIL,
        CMD_FCHK,
        CMD_RD_FNX,
        CMD_ADD_FNX,
        CMD_RD_PREV,
        CMD_ADD_PREV,
        CMD_FHDR,
        CMD_FFTR,
        CMD_RD_FNX2,
        CMD_WR_FNX2,
        CMD_FOK,
        CMD_FFAIL,
        CMD_PUSH
    } dp_cmd_t;

    typedef enum logic [4:0] {
        S_FMT_HDR,
        S_FMT_FTR,
        S_IDLE,
        S_ARD,
        S_ACHK,
        S_AEND,
        S_ASPL1,
        S_ASPL2,
        S_ANXRD,
        S_ANXWR,
        S_AHDR,
        S_AFAIL,
        S_FRD,
        S_FCHK,
        S_FNXRD,
        S_FNXADD,
        S_FPRD,
        S_FPADD,
        S_FHDR,
        S_FFTR,
        S_FNX2RD,
        S_FNX2WR,
        S_FOK,
        S_FFAIL,
        S_RES
    } state_t;

    typedef struct packed {
        logic req_op;
        logic req_zero;
        logic free_bad;
        logic pos_ge_end;
        logic brk;
        logic exact;
        logic hit;
        logic busy;
        logic found;
        logic split;
        logic anx_lt;
        logic fnx_lt;
        logic merge_prev;
        logic fnx2_lt;
        logic slot_free;
    } dp_status_t;

endpackage
`default_nettype wire

// ===== design/bfa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== design/bfa_ctrl.sv =====
// Controller: sequencer for format, allocate walk and free walk/merge.
`default_nettype none
module bfa_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    input  wire logic                cfg_wr,
    input  wire bfa_pkg::dp_status_t st,
    output bfa_pkg::dp_cmd_t         cmd,
    output logic                     req_stall
);

    bfa_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bfa_pkg::S_FMT_HDR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = bfa_pkg::CMD_NONE;
        req_stall  = 1'b1;
        unique case (state_reg)
            bfa_pkg::S_FMT_HDR:
            begin
                cmd        = bfa_pkg::CMD_FMT_HDR;
                state_next = bfa_pkg::S_FMT_FTR;
            end
            bfa_pkg::S_FMT_FTR:
            begin
                cmd        = bfa_pkg::CMD_FMT_FTR;
                state_next = bfa_pkg::S_IDLE;
            end
            bfa_pkg::S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd = bfa_pkg::CMD_LOAD;
                    if (st.req_op == bfa_pkg::OP_ALLOC)
                    begin
                        state_next = st.req_zero ? bfa_pkg::S_AFAIL : bfa_pkg::S_ARD;
                    end
                    else
                    begin
                        state_next = st.free_bad ? bfa_pkg::S_FFAIL : bfa_pkg::S_FRD;
                    end
                end
            end
            bfa_pkg::S_ARD:
            begin
                if (st.pos_ge_end)
                begin
                    state_next = bfa_pkg::S_AEND;
                end
                else
                begin
                    cmd        = bfa_pkg::CMD_RD_POS;
                    state_next = bfa_pkg::S_ACHK;
                end
            end
            bfa_pkg::S_ACHK:
            begin
                cmd        = bfa_pkg::CMD_ACHK;
                state_next = (st.brk || st.exact) ? bfa_pkg::S_AEND : bfa_pkg::S_ARD;
            end
            bfa_pkg::S_AEND:
            begin
                if (!st.found)
                begin
                    state_next = bfa_pkg::S_AFAIL;
                end
                else
                begin
                    state_next = st.split ? bfa_pkg::S_ASPL1 : bfa_pkg::S_ANXRD;
                end
            end
            bfa_pkg::S_ASPL1:
            begin
                cmd        = bfa_pkg::CMD_SPL_HDR;
                state_next = bfa_pkg::S_ASPL2;
            end
            bfa_pkg::S_ASPL2:
            begin
                cmd        = bfa_pkg::CMD_SPL_FTR;
                state_next = bfa_pkg::S_AHDR;
            end
            bfa_pkg::S_ANXRD:
            begin
                if (st.anx_lt)
                begin
                    cmd        = bfa_pkg::CMD_RD_ANX;
                    state_next = bfa_pkg::S_ANXWR;
                end
                else
                begin
                    state_next = bfa_pkg::S_AHDR;
                end
            end
            bfa_pkg::S_ANXWR:
            begin
                cmd        = bfa_pkg::CMD_WR_ANX;
                state_next = bfa_pkg::S_AHDR;
            end
            bfa_pkg::S_AHDR:
            begin
                cmd        = bfa_pkg::CMD_AHDR;
                state_next = bfa_pkg::S_RES;
            end
            bfa_pkg::S_AFAIL:
            begin
                cmd        = bfa_pkg::CMD_AFAIL;
                state_next = bfa_pkg::S_RES;
            end
            bfa_pkg::S_FRD:
            begin
                if (st.pos_ge_end)
                begin
                    state_next = bfa_pkg::S_FFAIL;
                end
                else
                begin
                    cmd        = bfa_pkg::CMD_RD_POS;
                    state_next = bfa_pkg::S_FCHK;
                end
            end
            bfa_pkg::S_FCHK:
            begin
                cmd = bfa_pkg::CMD_FCHK;
                if (st.brk)
                begin
                    state_next = bfa_pkg::S_FFAIL;
                end
                else if (st.hit)
                begin
                    state_next = st.busy ? bfa_pkg::S_FNXRD : bfa_pkg::S_FFAIL;
                end
                else
                begin
                    state_next = bfa_pkg::S_FRD;
                end
            end
            bfa_pkg::S_FNXRD:
            begin
                if (st.fnx_lt)
                begin
                    cmd        = bfa_pkg::CMD_RD_FNX;
                    state_next = bfa_pkg::S_FNXADD;
                end
                else
                begin
                    state_next = bfa_pkg::S_FPRD;
                end
            end
            bfa_pkg::S_FNXADD:
            begin
                cmd        = bfa_pkg::CMD_ADD_FNX;
                state_next = bfa_pkg::S_FPRD;
            end
            bfa_pkg::S_FPRD:
            begin
                if (st.merge_prev)
                begin
                    cmd        = bfa_pkg::CMD_RD_PREV;
                    state_next = bfa_pkg::S_FPADD;
                end
                else
                begin
                    state_next = bfa_pkg::S_FHDR;
                end
            end
            bfa_pkg::S_FPADD:
            begin
                cmd        = bfa_pkg::CMD_ADD_PREV;
                state_next = bfa_pkg::S_FHDR;
            end
            bfa_pkg::S_FHDR:
            begin
                cmd        = bfa_pkg::CMD_FHDR;
                state_next = bfa_pkg::S_FFTR;
            end
            bfa_pkg::S_FFTR:
            begin
                cmd        = bfa_pkg::CMD_FFTR;
                state_next = bfa_pkg::S_FNX2RD;
            end
            bfa_pkg::S_FNX2RD:
            begin
                if (st.fnx2_lt)
                begin
                    cmd        = bfa_pkg::CMD_RD_FNX2;
                    state_next = bfa_pkg::S_FNX2WR;
                end
                else
                begin
                    state_next = bfa_pkg::S_FOK;
                end
            end
            bfa_pkg::S_FNX2WR:
            begin
                cmd        = bfa_pkg::CMD_WR_FNX2;
                state_next = bfa_pkg::S_FOK;
            end
            bfa_pkg::S_FOK:
            begin
                cmd        = bfa_pkg::CMD_FOK;
                state_next = bfa_pkg::S_RES;
            end
            bfa_pkg::S_FFAIL:
            begin
                cmd        = bfa_pkg::CMD_FFAIL;
                state_next = bfa_pkg::S_RES;
            end
            bfa_pkg::S_RES:
            begin
                if (st.slot_free)
                begin
                    cmd        = bfa_pkg::CMD_PUSH;
                    state_next = bfa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bfa_pkg::S_FMT_HDR;
            end
        endcase
        if (cfg_wr)
        begin
            state_next = bfa_pkg::S_FMT_HDR;
        end
    end

endmodule
`default_nettype wire

// ===== design/bfa_dp.sv =====
// Datapath: heap size register, walk registers, tag RAM access and result register.
`default_nettype none
module bfa_dp #(
    parameter int HEAP_WORDS = bfa_pkg::HEAP_WORDS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire bfa_pkg::dp_cmd_t    cmd,
    input  wire bfa_pkg::req_t       req,
    input  wire logic                cfg_wr,
    input  wire logic [12:0]         cfg_data,
    output logic [12:0]              heap_bytes,
    output bfa_pkg::dp_status_t      st,
    output bfa_pkg::rsp_t            rsp,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall
);

    localparam int AW        = (HEAP_WORDS > 1) ? $clog2(HEAP_WORDS) : 1;
    localparam int LIMIT_INT = ((4 * HEAP_WORDS > bfa_pkg::HEAP_MAX) ?
                                bfa_pkg::HEAP_MAX : 4 * HEAP_WORDS) & ~7;
    localparam int RESET_INT = (bfa_pkg::HEAP_RESET > LIMIT_INT) ?
                               LIMIT_INT : bfa_pkg::HEAP_RESET;
    localparam logic [12:0] LIMIT    = 13'(LIMIT_INT);
    localparam logic [12:0] HEAP_RST = 13'(RESET_INT);

    logic [12:0] heap_reg;
    logic [13:0] need_reg;
    logic [12:0] h_reg, pos_reg, prev_reg, best_reg, bsz_reg, start_reg, total_reg;
    logic        found_reg, bprev_reg;
    logic [15:0] tag_reg;
    logic [11:0] pend_addr_reg;
    logic [1:0]  pend_status_reg;
    bfa_pkg::rsp_t rsp_reg;
    logic        rsp_valid_reg;

    logic          we, re;
    logic [12:0]   wpos, rpos;
    logic [15:0]   wdata, t;

    logic [12:0] cfg_clamped, end_w, sz_t, sz_tag, rest, anx, fnx, fnx2, hsize;
    logic [13:0] pos_sz, h_ext;
    logic        brk, fit, better, exact;

    always_comb
    begin
        cfg_clamped = {cfg_data[12:3], 3'b000};
        if (cfg_clamped < 13'(bfa_pkg::HEAP_MIN))
        begin
            cfg_clamped = 13'(bfa_pkg::HEAP_MIN);
        end
        if (cfg_clamped > LIMIT)
        begin
            cfg_clamped = LIMIT;
        end
    end

    assign end_w  = heap_reg - 13'd4;
    assign sz_t   = {t[12:2], 2'b00};
    assign sz_tag = {tag_reg[12:2], 2'b00};
    assign pos_sz = {1'b0, pos_reg} + {1'b0, sz_t};
    assign brk    = (sz_t == 13'd0) || (pos_sz > {1'b0, end_w});
    assign fit    = !t[0] && ({1'b0, sz_t} >= need_reg);
    assign better = fit && (!found_reg || (sz_t < bsz_reg));
    assign exact  = fit && ({1'b0, sz_t} == need_reg);
    assign rest   = bsz_reg - need_reg[12:0];
    assign anx    = best_reg + bsz_reg;
    assign fnx    = h_reg + sz_tag;
    assign fnx2   = start_reg + total_reg;
    assign hsize  = (rest >= 13'd8) ? need_reg[12:0] : bsz_reg;
    assign h_ext  = {2'b00, req.payload_address} - 14'd4;

    always_comb
    begin
        st.req_op     = req.operation;
        st.req_zero   = (req.request_bytes == 13'd0);
        st.free_bad   = (req.payload_address == 12'd0) || (req.payload_address[2:0] != 3'd0)
                        || (req.payload_address < 12'd8) || (h_ext >= {1'b0, end_w});
        st.pos_ge_end = (pos_reg >= end_w);
        st.brk        = brk;
        st.exact      = exact;
        st.hit        = (pos_reg == h_reg);
        st.busy       = t[0];
        st.found      = found_reg;
        st.split      = (rest >= 13'd8);
        st.anx_lt     = (anx < end_w);
        st.fnx_lt     = (fnx < end_w);
        st.merge_prev = !tag_reg[1] && (prev_reg != 13'd0);
        st.fnx2_lt    = (fnx2 < end_w);
        st.slot_free  = !rsp_valid_reg || !rsp_stall;
    end

    always_comb
    begin
        we    = 1'b0;
        re    = 1'b0;
        wpos  = best_reg;
        rpos  = pos_reg;
        wdata = 16'd0;
        case (cmd)
            bfa_pkg::CMD_FMT_HDR:
            begin
                we    = 1'b1;
                wpos  = 13'd4;
                wdata = {3'b000, heap_reg - 13'd8} | 16'd2;
            end
            bfa_pkg::CMD_FMT_FTR:
            begin
                we    = 1'b1;
                wpos  = heap_reg - 13'd8;
                wdata = {3'b000, heap_reg - 13'd8};
            end
            bfa_pkg::CMD_RD_POS:
            begin
                re   = 1'b1;
                rpos = pos_reg;
            end
            bfa_pkg::CMD_SPL_HDR:
            begin
                we    = 1'b1;
                wpos  = best_reg + need_reg[12:0];
                wdata = {3'b000, rest} | 16'd2;
            end
            bfa_pkg::CMD_SPL_FTR:
            begin
                we    = 1'b1;
                wpos  = anx - 13'd4;
                wdata = {3'b000, rest};
            end
            bfa_pkg::CMD_RD_ANX:
            begin
                re   = 1'b1;
                rpos = anx;
            end
            bfa_pkg::CMD_WR_ANX:
            begin
                we    = 1'b1;
                wpos  = anx;
                wdata = t | 16'd2;
            end
            bfa_pkg::CMD_AHDR:
            begin
                we    = 1'b1;
                wpos  = best_reg;
                wdata = {3'b000, hsize} | 16'd1 | {14'd0, bprev_reg, 1'b0};
            end
            bfa_pkg::CMD_RD_FNX:
            begin
                re   = 1'b1;
                rpos = fnx;
            end
            bfa_pkg::CMD_RD_PREV:
            begin
                re   = 1'b1;
                rpos = prev_reg;
            end
            bfa_pkg::CMD_FHDR:
            begin
                we    = 1'b1;
                wpos  = start_reg;
                wdata = {3'b000, total_reg} | 16'd2;
            end
            bfa_pkg::CMD_FFTR:
            begin
                we    = 1'b1;
                wpos  = fnx2 - 13'd4;
                wdata = {3'b000, total_reg};
            end
            bfa_pkg::CMD_RD_FNX2:
            begin
                re   = 1'b1;
                rpos = fnx2;
            end
            bfa_pkg::CMD_WR_FNX2:
            begin
                we    = 1'b1;
                wpos  = fnx2;
                wdata = t & ~16'd2;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    bfa_ram #(
        .WIDTH (bfa_pkg::TAG_W),
        .DEPTH (HEAP_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (AW'(wpos >> 2)),
        .wdata (wdata),
        .re    (re),
        .raddr (AW'(rpos >> 2)),
        .rdata (t)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_reg      <= HEAP_RST;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                heap_reg <= cfg_clamped;
            end
            if (cmd == bfa_pkg::CMD_PUSH)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd)
            bfa_pkg::CMD_LOAD:
            begin
                need_reg  <= ({1'b0, req.request_bytes} + 14'd11) & ~14'd7;
                h_reg     <= h_ext[12:0];
                pos_reg   <= 13'd4;
                prev_reg  <= 13'd0;
                found_reg <= 1'b0;
            end
            bfa_pkg::CMD_ACHK:
            begin
                if (!brk)
                begin
                    if (better)
                    begin
                        found_reg <= 1'b1;
                        best_reg  <= pos_reg;
                        bsz_reg   <= sz_t;
                        bprev_reg <= t[1];
                    end
                    pos_reg <= pos_sz[12:0];
                end
            end
            bfa_pkg::CMD_FCHK:
            begin
                if (!brk)
                begin
                    if (pos_reg == h_reg)
                    begin
                        tag_reg   <= t;
                        start_reg <= h_reg;
                        total_reg <= sz_t;
                    end
                    else
                    begin
                        prev_reg <= pos_reg;
                        pos_reg  <= pos_sz[12:0];
                    end
                end
            end
            bfa_pkg::CMD_ADD_FNX:
            begin
                if (!t[0])
                begin
                    total_reg <= total_reg + sz_t;
                end
            end
            bfa_pkg::CMD_ADD_PREV:
            begin
                start_reg <= prev_reg;
                total_reg <= total_reg + sz_t;
            end
            bfa_pkg::CMD_AHDR:
            begin
                pend_addr_reg   <= best_reg[11:0] + 12'd4;
                pend_status_reg <= bfa_pkg::ST_OK;
            end
            bfa_pkg::CMD_AFAIL:
            begin
                pend_addr_reg   <= 12'd0;
                pend_status_reg <= bfa_pkg::ST_ALLOC_FAIL;
            end
            bfa_pkg::CMD_FOK:
            begin
                pend_addr_reg   <= 12'd0;
                pend_status_reg <= bfa_pkg::ST_OK;
            end
            bfa_pkg::CMD_FFAIL:
            begin
                pend_addr_reg   <= 12'd0;
                pend_status_reg <= bfa_pkg::ST_FREE_FAIL;
            end
            bfa_pkg::CMD_PUSH:
            begin
                rsp_reg.address <= pend_addr_reg;
                rsp_reg.status  <= pend_status_reg;
            end
            default:
            begin
                found_reg <= found_reg;
            end
        endcase
    end

    assign heap_bytes = heap_reg;
    assign rsp        = rsp_reg;
    assign rsp_valid  = rsp_valid_reg;

endmodule
`default_nettype wire

// ===== design/best_fit_heap_allocator.sv =====
// Top level: best-fit boundary-tag heap allocator with APB heap size register.
// An allocate walks every block header in the heap, one tag RAM read per block,
// stopping early on an exact fit or a broken tag, then splits or marks the block and
// posts the beat. A free walks headers up to the target block and then merges it with
// its free neighbours. After reset and after each heap_bytes write the heap is
// formatted by writing a header and a footer, with req_stall high. One item is worked
// at a time; a finished beat waits in the output register while the next item is taken.
`default_nettype none
module best_fit_heap_allocator #(
    parameter int HEAP_WORDS = bfa_pkg::HEAP_WORDS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire bfa_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output bfa_pkg::rsp_t      rsp,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [1:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    bfa_pkg::dp_cmd_t    cmd;
    bfa_pkg::dp_status_t st;
    logic                cfg_wr;
    logic [12:0]         heap_bytes;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == bfa_pkg::REG_HEAP_BYTES);
    assign prdata = (paddr == bfa_pkg::REG_HEAP_BYTES) ? {19'd0, heap_bytes} : 32'd0;

    bfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .cfg_wr    (cfg_wr),
        .st        (st),
        .cmd       (cmd),
        .req_stall (req_stall)
    );

    bfa_dp #(
        .HEAP_WORDS (HEAP_WORDS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .req        (req),
        .cfg_wr     (cfg_wr),
        .cfg_data   (pwdata[12:0]),
        .heap_bytes (heap_bytes),
        .st         (st),
        .rsp        (rsp),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall)
    );

endmodule
`default_nettype wire

// ===== design/bfa_checker.sv =====
// Checker: port-level assertions of the heap allocator, bound to the top level.
`default_nettype none
module bfa_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          rsp_valid,
    input wire logic          rsp_stall,
    input wire bfa_pkg::rsp_t rsp,
    input wire logic          pready
);

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled beat changed");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.status == bfa_pkg::ST_OK) || (rsp.status == bfa_pkg::ST_ALLOC_FAIL)
                      || (rsp.status == bfa_pkg::ST_FREE_FAIL))
        else $error("bad status code");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != bfa_pkg::ST_OK) |-> rsp.address == 12'd0)
        else $error("failed beat carries an address");

    a_align: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == bfa_pkg::ST_OK) |-> rsp.address[2:0] == 3'd0)
        else $error("granted payload misaligned");

endmodule

bind best_fit_heap_allocator bfa_checker u_bfa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .pready    (pready)
);
`default_nettype wire
